// File: src/mcbs_pkg.sv
// constants, widths and helpers for the memory card block store
// no dependencies; used by memory_card_block_store
package mcbs_pkg;

	localparam int NUM_BLOCKS  = 256;
	localparam int BLOCK_WORDS = 128;
	localparam int PHASES      = 4;
	localparam int PHASE_WORDS = 32;

	localparam int STORE_WORDS = NUM_BLOCKS * BLOCK_WORDS;
	localparam int STAGE_WORDS = PHASES * PHASE_WORDS;
	localparam int READ_PAIRS  = (BLOCK_WORDS + 1) / 2;

	// address and counter widths
	localparam int SA_W = $clog2(STORE_WORDS);
	localparam int SB_W = (STAGE_WORDS > 1) ? $clog2(STAGE_WORDS) : 1;
	localparam int WC_W = $clog2(BLOCK_WORDS + 1);
	localparam int PC_W = $clog2(READ_PAIRS + 1);

	// command codes
	localparam logic [1:0] CMD_READ     = 2'd0;
	localparam logic [1:0] CMD_WRITE    = 2'd1;
	localparam logic [1:0] CMD_COMPLETE = 2'd2;

	// fixed part of the check header: length word, function word
	localparam logic [31:0] HDR_CONST = 32'h0000_0008
		^ (32'((BLOCK_WORDS + 2) & 32'hFF) << 24)
		^ 32'h0200_0000;

	// final fold of the check word
	function automatic logic [31:0] fold_check(input logic [31:0] v);
		logic [31:0] y;
		y = v ^ (v << 16);
		return y ^ (y << 8);
	endfunction

endpackage

// File: src/memory_card_block_store.sv
// memory card block store: block read streaming with check word, staged block write
// depends on mcbs_pkg (constants, command codes, check fold)
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------------
//  in       | sink      | in_valid / in_stall  | cmd, block, phase, word_index, data_word
//  out      | source    | out_valid / out_stall| data_pair, check_word, status, committed, last
//  cfg      | sink      | cfg_write            | cfg_data (port address byte)
//
// read: one word pair per cycle from a dual read port on the card store while the output
//   does not stall, 64 pairs per block; the store read port sets the rate
// complete with a pending block: one store word written per cycle, BLOCK_WORDS words in all
// other commands: one result
// reset clears control, the staging valid bits and the pending marker; the card store
//   is not cleared and needs no clearing pass
// output stalls hold the output register and pause store reads; new items are taken only
//   once the previous item has handed its last transaction to the output register
module memory_card_block_store (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  block,
	input  logic [7:0]  phase,
	input  logic [5:0]  word_index,
	input  logic [31:0] data_word,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] data_pair,
	output logic [31:0] check_word,
	output logic        status,
	output logic        committed,
	output logic        last
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	// memories
	logic [31:0] card_store [mcbs_pkg::STORE_WORDS];
	logic [31:0] stage_mem  [mcbs_pkg::STAGE_WORDS];

	// control state
	logic [1:0]                         state_q;
	logic [7:0]                         port_q;
	logic                               pend_valid_q;
	logic [7:0]                         pend_blk_q;
	logic [mcbs_pkg::PHASES-1:0]        mask_q;
	logic                               save_q;
	logic [mcbs_pkg::STAGE_WORDS-1:0]   sb_valid_q;
	logic                               out_valid_q;
	logic                               rd_pend_q;
	logic                               cm_wr_s1;

	// datapath registers
	logic [mcbs_pkg::SA_W-1:0] base_q;
	logic [31:0]               acc_q;
	logic [mcbs_pkg::PC_W-1:0] issue_cnt_q;
	logic [mcbs_pkg::WC_W-1:0] cm_cnt_q;
	logic                      resp_commit_q;
	logic [31:0]               rd_lo_s1;
	logic [31:0]               rd_hi_s1;
	logic                      rd_hi_ok_s1;
	logic                      rd_last_s1;
	logic [31:0]               sb_rd_s1;
	logic                      sb_ok_s1;
	logic [mcbs_pkg::SA_W-1:0] cm_addr_s1;
	logic [63:0]               out_pair_q;
	logic [31:0]               out_check_q;
	logic                      out_status_q;
	logic                      out_commit_q;
	logic                      out_last_q;

	// handshakes
	logic accept;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// decode of the accepted item
	logic                      blk_ok;
	logic [7:0]                blk_eff;
	logic                      ph_ok;
	logic                      idx_ok;
	logic                      wr_ok;
	logic                      blk_change;
	logic                      can_commit;
	logic [mcbs_pkg::SB_W-1:0] wr_sb_addr;

	assign blk_ok     = ({24'd0, block} < 32'(mcbs_pkg::NUM_BLOCKS));
	assign blk_eff    = blk_ok ? block : 8'd0;
	assign ph_ok      = ({24'd0, phase} < 32'(mcbs_pkg::PHASES));
	assign idx_ok     = ({26'd0, word_index} < 32'(mcbs_pkg::PHASE_WORDS));
	assign wr_ok      = blk_ok && ph_ok;
	assign blk_change = !pend_valid_q || (pend_blk_q != block);
	assign can_commit = pend_valid_q && (mask_q != '0);
	// phase is in range wherever this address is used
	assign wr_sb_addr = mcbs_pkg::SB_W'(phase) * mcbs_pkg::SB_W'(mcbs_pkg::PHASE_WORDS)
		+ mcbs_pkg::SB_W'(word_index);

	logic wr_stage;
	assign wr_stage = accept && (cmd == mcbs_pkg::CMD_WRITE) && wr_ok && idx_ok;

	// read sequencing: issue pair reads while the output side keeps up
	logic                      rd_more;
	logic                      rd_issue;
	logic                      rd_load;
	logic [mcbs_pkg::WC_W-1:0] lo_idx;
	logic [mcbs_pkg::WC_W-1:0] hi_idx;
	logic                      hi_ok;
	logic [mcbs_pkg::SA_W-1:0] addr_lo;
	logic [mcbs_pkg::SA_W-1:0] addr_hi;
	logic [31:0]               pair_hi;
	logic [31:0]               acc_next;

	assign rd_more  = issue_cnt_q < mcbs_pkg::PC_W'(mcbs_pkg::READ_PAIRS);
	assign rd_issue = (state_q == ST_READ) && rd_more && (!rd_pend_q || out_free);
	assign rd_load  = (state_q == ST_READ) && rd_pend_q && out_free;
	assign lo_idx   = mcbs_pkg::WC_W'({issue_cnt_q, 1'b0});
	assign hi_idx   = lo_idx + mcbs_pkg::WC_W'(1);
	// odd word past the block end reads as zero
	assign hi_ok    = hi_idx < mcbs_pkg::WC_W'(mcbs_pkg::BLOCK_WORDS);
	assign addr_lo  = base_q + mcbs_pkg::SA_W'(lo_idx);
	assign addr_hi  = hi_ok ? (base_q + mcbs_pkg::SA_W'(hi_idx)) : addr_lo;
	assign pair_hi  = rd_hi_ok_s1 ? rd_hi_s1 : 32'd0;
	assign acc_next = acc_q ^ rd_lo_s1 ^ pair_hi;

	// output register takes a read pair or a single status transaction
	logic out_load;
	assign out_load = rd_load || ((state_q == ST_RESP) && out_free);

	// commit sequencing: one stage word read and one store word written per cycle
	logic                      cm_issue;
	logic                      cm_done;
	logic [mcbs_pkg::SB_W-1:0] cm_sb_idx;
	logic                      cm_in_stage;

	assign cm_issue    = (state_q == ST_COMMIT) &&
		(cm_cnt_q < mcbs_pkg::WC_W'(mcbs_pkg::BLOCK_WORDS));
	assign cm_done     = (state_q == ST_COMMIT) && !cm_issue;
	assign cm_sb_idx   = mcbs_pkg::SB_W'(cm_cnt_q);
	assign cm_in_stage = (32'(cm_cnt_q) < mcbs_pkg::STAGE_WORDS);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			port_q       <= 8'd1;
			pend_valid_q <= 1'b0;
			pend_blk_q   <= 8'd0;
			mask_q       <= '0;
			save_q       <= 1'b0;
			sb_valid_q   <= '0;
			out_valid_q  <= 1'b0;
			rd_pend_q    <= 1'b0;
			cm_wr_s1     <= 1'b0;
		end else begin
			if (cfg_write) begin
				port_q <= cfg_data;
			end

			rd_pend_q   <= rd_issue || (rd_pend_q && !out_free);
			cm_wr_s1    <= cm_issue;
			out_valid_q <= out_load || (out_valid_q && out_stall);

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							mcbs_pkg::CMD_READ: begin
								state_q <= ST_READ;
							end
							mcbs_pkg::CMD_WRITE: begin
								if (wr_ok) begin
									pend_valid_q <= 1'b1;
									pend_blk_q   <= block;
									save_q       <= 1'b1;
									// a new block starts from an empty buffer
									if (blk_change) begin
										mask_q     <= mcbs_pkg::PHASES'(1) << phase;
										sb_valid_q <= idx_ok ?
											(mcbs_pkg::STAGE_WORDS'(1) << wr_sb_addr) : '0;
									end else begin
										mask_q     <= mask_q | (mcbs_pkg::PHASES'(1) << phase);
										sb_valid_q <= sb_valid_q | (idx_ok ?
											(mcbs_pkg::STAGE_WORDS'(1) << wr_sb_addr) : '0);
									end
								end
								state_q <= ST_RESP;
							end
							mcbs_pkg::CMD_COMPLETE: begin
								state_q <= can_commit ? ST_COMMIT : ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_READ: begin
					if (rd_load && rd_last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COMMIT: begin
					// last store write lands on this edge; buffer keeps its data
					if (cm_done) begin
						pend_valid_q <= 1'b0;
						pend_blk_q   <= 8'd0;
						mask_q       <= '0;
						save_q       <= 1'b0;
						state_q      <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			resp_commit_q <= 1'b0;
			issue_cnt_q   <= '0;
			cm_cnt_q      <= '0;
			if (cmd == mcbs_pkg::CMD_READ) begin
				base_q <= mcbs_pkg::SA_W'(blk_eff) * mcbs_pkg::SA_W'(mcbs_pkg::BLOCK_WORDS);
				acc_q  <= mcbs_pkg::HDR_CONST ^ {8'd0, port_q, 16'd0} ^ {24'd0, blk_eff};
			end else begin
				base_q <= mcbs_pkg::SA_W'(pend_blk_q) * mcbs_pkg::SA_W'(mcbs_pkg::BLOCK_WORDS);
			end
		end

		if (rd_issue) begin
			issue_cnt_q <= issue_cnt_q + mcbs_pkg::PC_W'(1);
			rd_hi_ok_s1 <= hi_ok;
			rd_last_s1  <= (issue_cnt_q == mcbs_pkg::PC_W'(mcbs_pkg::READ_PAIRS - 1));
		end
		if (rd_load) begin
			acc_q <= acc_next;
		end

		if (cm_issue) begin
			cm_cnt_q   <= cm_cnt_q + mcbs_pkg::WC_W'(1);
			sb_ok_s1   <= cm_in_stage && sb_valid_q[cm_sb_idx];
			cm_addr_s1 <= base_q + mcbs_pkg::SA_W'(cm_cnt_q);
		end
		if (cm_done) begin
			resp_commit_q <= 1'b1;
		end

		// output register loads
		if (rd_load) begin
			out_pair_q   <= {pair_hi, rd_lo_s1};
			out_check_q  <= rd_last_s1 ? mcbs_pkg::fold_check(acc_next) : 32'd0;
			out_status_q <= save_q;
			out_commit_q <= 1'b0;
			out_last_q   <= rd_last_s1;
		end else if ((state_q == ST_RESP) && out_free) begin
			out_pair_q   <= 64'd0;
			out_check_q  <= 32'd0;
			out_status_q <= save_q;
			out_commit_q <= resp_commit_q;
			out_last_q   <= 1'b1;
		end
	end

	// card store: commit write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cm_wr_s1) begin
			card_store[cm_addr_s1] <= sb_ok_s1 ? sb_rd_s1 : 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_lo_s1 <= card_store[addr_lo];
			rd_hi_s1 <= card_store[addr_hi];
		end
	end

	// staging buffer: word write on accept, registered read during commit
	always_ff @(posedge clk) begin
		if (wr_stage) begin
			stage_mem[wr_sb_addr] <= data_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cm_issue) begin
			sb_rd_s1 <= stage_mem[cm_sb_idx];
		end
	end

	assign out_valid  = out_valid_q;
	assign data_pair  = out_pair_q;
	assign check_word = out_check_q;
	assign status     = out_status_q;
	assign committed  = out_commit_q;
	assign last       = out_last_q;

endmodule

// File: bench/tb.sv
// self-checking bench for memory_card_block_store: directed table, then random traffic
// depends on mcbs_pkg and memory_card_block_store; carries its own model of the card
`timescale 1ns / 100ps

module tb;

	// no-op code, not named in the package
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400_000;
	localparam int CHUNK_ITEMS = 45;
	// commit copies the whole block, so let that much time pass before touching config
	localparam int SETTLE_CYCLES = mcbs_pkg::BLOCK_WORDS + 4;

	// one input transaction, plus a typed expectation for the simple rows
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  blk;
		logic [7:0]  ph;
		logic [5:0]  wi;
		logic [31:0] word;
		logic        typed;
		logic        exp_status;
		logic        exp_committed;
	} card_item_t;

	// one output transaction
	typedef struct packed {
		logic [63:0] pair;
		logic [31:0] chk;
		logic        st;
		logic        cm;
		logic        lst;
	} card_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [7:0]  block;
	logic [7:0]  phase;
	logic [5:0]  word_index;
	logic [31:0] data_word;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] data_pair;
	logic [31:0] check_word;
	logic        status;
	logic        committed;
	logic        last;

	memory_card_block_store dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.block      (block),
		.phase      (phase),
		.word_index (word_index),
		.data_word  (data_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_pair  (data_pair),
		.check_word (check_word),
		.status     (status),
		.committed  (committed),
		.last       (last)
	);

	// ---------------------------------------------------------------------
	// model state of the card
	// ---------------------------------------------------------------------
	logic [31:0]                 card_image [mcbs_pkg::STORE_WORDS];
	bit                          block_written [mcbs_pkg::NUM_BLOCKS];
	logic [7:0]                  written_list [$];
	logic [31:0]                 stage_words [mcbs_pkg::STAGE_WORDS];
	bit                          pend_valid;
	logic [7:0]                  pend_block;
	logic [mcbs_pkg::PHASES-1:0] phase_marks;
	logic                        saving;
	logic [7:0]                  port_byte;

	card_result_t owed_results [$];

	int  error_count;
	int  items_taken;
	int unsigned cycle_count;
	bit  calm;       // no idling on either side
	bit  hold_req;   // receiver holds off for a long stretch

	// directed part: extremes, every command and each corner of the write path
	localparam card_item_t DIRECTED [23] = '{
		// complete with nothing pending
		'{mcbs_pkg::CMD_COMPLETE, 8'h00, 8'h00, 6'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
		// no-op with every field at its top
		'{CMD_NOP,                8'hFF, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
		// phase out of range with nothing pending: ignored
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'hFF, 6'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h00, 6'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h03, 6'h1F, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
		// index past the phase: word dropped, phase still marked
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h01, 6'h20, 32'h1234_5678, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h02, 6'h3F, 32'hA5A5_A5A5, 1'b1, 1'b1, 1'b0},
		// first phase out of range while pending
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h04, 6'h01, 32'h0000_DEAD, 1'b1, 1'b1, 1'b0},
		// block change clears the staging buffer
		'{mcbs_pkg::CMD_WRITE,    8'hFF, 8'h00, 6'h00, 32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'hFF, 8'h03, 6'h1F, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'hFF, 8'h01, 6'h05, 32'h8000_0001, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_COMPLETE, 8'h00, 8'h00, 6'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
		// second complete finds nothing pending
		'{mcbs_pkg::CMD_COMPLETE, 8'hFF, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
		'{mcbs_pkg::CMD_READ,     8'hFF, 8'h00, 6'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h00, 6'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h02, 6'h11, 32'h0000_0001, 1'b1, 1'b1, 1'b0},
		// no-op keeps the saving status
		'{CMD_NOP,                8'h00, 8'h00, 6'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
		// read while a write is pending reports saving
		'{mcbs_pkg::CMD_READ,     8'hFF, 8'h00, 6'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{mcbs_pkg::CMD_COMPLETE, 8'h00, 8'h00, 6'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
		'{mcbs_pkg::CMD_READ,     8'h00, 8'h00, 6'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		// same block after a commit starts a fresh buffer
		'{mcbs_pkg::CMD_WRITE,    8'h00, 8'h01, 6'h00, 32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0},
		'{mcbs_pkg::CMD_COMPLETE, 8'h00, 8'h00, 6'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
		// read ignores the other fields
		'{mcbs_pkg::CMD_READ,     8'h00, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}
	};

	// ---------------------------------------------------------------------
	// clock, timeout
	// ---------------------------------------------------------------------
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("memory_card_block_store regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// card model
	// ---------------------------------------------------------------------
	function automatic logic [31:0] stored_word(input logic [7:0] blk, input int w);
		// words past the block read as zero
		return (w < mcbs_pkg::BLOCK_WORDS) ?
			card_image[int'(blk) * mcbs_pkg::BLOCK_WORDS + w] : 32'd0;
	endfunction

	// applies one transaction to the model and returns the responses it causes
	function automatic void card_respond(input card_item_t it, ref card_result_t res[$]);
		card_result_t r;
		logic [31:0]  chk;
		logic [31:0]  lo;
		logic [31:0]  hi;
		logic [7:0]   len_byte;
		res.delete();
		r = '0;
		r.lst = 1'b1;
		case (it.op)
			mcbs_pkg::CMD_READ: begin
				// header words, function word and block number, then every data word
				len_byte = 8'(mcbs_pkg::BLOCK_WORDS + 2);
				chk = {len_byte, port_byte, 16'h0008} ^ 32'h0200_0000 ^ {24'd0, it.blk};
				for (int k = 0; k < mcbs_pkg::READ_PAIRS; k++)
					chk ^= stored_word(it.blk, 2 * k) ^ stored_word(it.blk, 2 * k + 1);
				chk ^= chk << 16;
				chk ^= chk << 8;
				for (int k = 0; k < mcbs_pkg::READ_PAIRS; k++) begin
					lo = stored_word(it.blk, 2 * k);
					hi = stored_word(it.blk, 2 * k + 1);
					r.pair = {hi, lo};
					r.lst = (k == mcbs_pkg::READ_PAIRS - 1);
					r.chk = r.lst ? chk : 32'd0;
					r.st = saving;
					res.push_back(r);
				end
			end
			mcbs_pkg::CMD_WRITE: begin
				if (it.ph < mcbs_pkg::PHASES) begin
					if (!pend_valid || pend_block != it.blk) begin
						pend_valid = 1'b1;
						pend_block = it.blk;
						phase_marks = '0;
						foreach (stage_words[i])
							stage_words[i] = '0;
					end
					if (it.wi < mcbs_pkg::PHASE_WORDS)
						stage_words[int'(it.ph) * mcbs_pkg::PHASE_WORDS + int'(it.wi)] = it.word;
					phase_marks[it.ph] = 1'b1;
					saving = 1'b1;
				end
				r.st = saving;
				res.push_back(r);
			end
			mcbs_pkg::CMD_COMPLETE: begin
				if (pend_valid && phase_marks != '0) begin
					for (int i = 0; i < mcbs_pkg::BLOCK_WORDS; i++)
						card_image[int'(pend_block) * mcbs_pkg::BLOCK_WORDS + i] =
							(i < mcbs_pkg::STAGE_WORDS) ? stage_words[i] : 32'd0;
					if (!block_written[pend_block]) begin
						block_written[pend_block] = 1'b1;
						written_list.push_back(pend_block);
					end
					pend_valid = 1'b0;
					pend_block = '0;
					phase_marks = '0;
					saving = 1'b0;
					r.cm = 1'b1;
				end
				r.st = saving;
				res.push_back(r);
			end
			default: begin
				r.st = saving;
				res.push_back(r);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------------
	function automatic card_item_t make_item(input logic [1:0] op, input logic [7:0] blk,
			input logic [7:0] ph, input logic [5:0] wi, input logic [31:0] word);
		return '{op, blk, ph, wi, word, 1'b0, 1'b0, 1'b0};
	endfunction

	// offers one transaction, now and then with a random gap ahead of it, and books its responses
	task automatic offer_item(input card_item_t it);
		card_result_t got [$];
		card_result_t typed_r;
		if (!calm && $urandom_range(99, 0) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= it.op;
		block      <= it.blk;
		phase      <= it.ph;
		word_index <= it.wi;
		data_word  <= it.word;
		do
			@(posedge clk);
		while (in_stall);
		card_respond(it, got);
		if (it.typed) begin
			typed_r = '0;
			typed_r.st = it.exp_status;
			typed_r.cm = it.exp_committed;
			typed_r.lst = 1'b1;
			owed_results.push_back(typed_r);
		end else begin
			foreach (got[i])
				owed_results.push_back(got[i]);
		end
		items_taken++;
	endtask

	// sender pauses until every booked response is back, then lets the block settle
	task automatic drain_block();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_port_address(input logic [7:0] v);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		port_byte = v;
	endtask

	// well-formed block write: a run of words to one block, usually closed by a complete
	task automatic write_sequence(input bit close);
		logic [7:0] blk;
		logic [5:0] wi;
		int         n;
		blk = 8'($urandom_range(255, 0));
		n = $urandom_range(10, 1);
		repeat (n) begin
			// now and then an index past the phase
			wi = ($urandom_range(9, 0) == 0) ? 6'($urandom_range(63, mcbs_pkg::PHASE_WORDS))
				: 6'($urandom_range(mcbs_pkg::PHASE_WORDS - 1, 0));
			offer_item(make_item(mcbs_pkg::CMD_WRITE, blk,
				8'($urandom_range(mcbs_pkg::PHASES - 1, 0)), wi, $urandom()));
		end
		if (close)
			offer_item(make_item(mcbs_pkg::CMD_COMPLETE, 8'($urandom()), 8'($urandom()),
				6'($urandom()), $urandom()));
	endtask

	// reads only ever target blocks that a commit has filled
	task automatic read_written();
		logic [7:0] blk;
		blk = written_list[$urandom_range(written_list.size() - 1, 0)];
		offer_item(make_item(mcbs_pkg::CMD_READ, blk, 8'($urandom()), 6'($urandom()),
			$urandom()));
	endtask

	task automatic noise_item();
		case ($urandom_range(3, 0))
			0: offer_item(make_item(CMD_NOP, 8'($urandom()), 8'($urandom()),
				6'($urandom()), $urandom()));
			1: offer_item(make_item(mcbs_pkg::CMD_COMPLETE, 8'($urandom()), 8'($urandom()),
				6'($urandom()), $urandom()));
			// phase out of range
			2: offer_item(make_item(mcbs_pkg::CMD_WRITE, 8'($urandom()),
				8'($urandom_range(255, mcbs_pkg::PHASES)), 6'($urandom()), $urandom()));
			// stray write, likely a block change under a pending sequence
			default: offer_item(make_item(mcbs_pkg::CMD_WRITE, 8'($urandom()),
				8'($urandom_range(mcbs_pkg::PHASES - 1, 0)), 6'($urandom()), $urandom()));
		endcase
	endtask

	task automatic run_random_chunk(input int quota);
		int start;
		int pick;
		start = items_taken;
		while (items_taken - start < quota) begin
			pick = $urandom_range(99, 0);
			if (pick < 45 || written_list.size() == 0)
				write_sequence($urandom_range(9, 0) != 0);
			else if (pick < 68)
				read_written();
			else
				noise_item();
		end
	endtask

	// ---------------------------------------------------------------------
	// receiver side: random stalls, a calm stretch, one long hold-off
	// ---------------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// output backs up, the block stops taking transactions
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= calm ? 1'b0 : ($urandom_range(99, 0) < 26);
			end
		end
	end

	// compares each accepted response with the oldest booked one
	always @(posedge clk) begin
		card_result_t seen;
		card_result_t want;
		if (out_valid && !out_stall) begin
			seen = '{data_pair, check_word, status, committed, last};
			if (owed_results.size() == 0) begin
				if (error_count < 10)
					$display("unexpected: pair %h check %h status %b committed %b last %b",
						data_pair, check_word, status, committed, last);
				error_count++;
			end else begin
				want = owed_results.pop_front();
				if (seen !== want) begin
					if (error_count < 10)
						$display(
							"mismatch exp/act: pair %h/%h chk %h/%h st %b/%b cm %b/%b lst %b/%b",
							want.pair, seen.pair, want.chk, seen.chk, want.st, seen.st,
							want.cm, seen.cm, want.lst, seen.lst);
					error_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------
	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_data   = 8'd0;
		in_valid   = 1'b0;
		cmd        = CMD_NOP;
		block      = 8'd0;
		phase      = 8'd0;
		word_index = 6'd0;
		data_word  = 32'd0;
		// model after reset
		pend_valid  = 1'b0;
		pend_block  = '0;
		phase_marks = '0;
		saving      = 1'b0;
		port_byte   = 8'd1;
		foreach (stage_words[i])
			stage_words[i] = '0;
		calm     = 1'b0;
		hold_req = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset port address
		foreach (DIRECTED[i])
			offer_item(DIRECTED[i]);

		// random traffic, a fresh port address in each chunk: both extremes first
		for (int chunk = 0; chunk < 5; chunk++) begin
			drain_block();
			set_port_address(chunk == 0 ? 8'h00 : chunk == 1 ? 8'hFF : 8'($urandom()));
			if (chunk == 1) begin
				// long hold-off with reads queued behind it
				hold_req = 1'b1;
				read_written();
				read_written();
			end
			calm = (chunk == 2);
			run_random_chunk(CHUNK_ITEMS);
		end
		calm = 1'b0;
		drain_block();

		if (error_count == 0 && owed_results.size() == 0)
			$display("memory_card_block_store regression: pass");
		else
			$display("memory_card_block_store regression: fail");
		$finish;
	end

endmodule

// File: sim.f
src/mcbs_pkg.sv
src/memory_card_block_store.sv
bench/tb.sv
